FILE: design/utf8_stream_validator_macros.svh
// Assertion macros for the UTF-8 stream validator.
// Used by the top level; expects clk and rst_n in scope.
`ifndef UTF8_STREAM_VALIDATOR_MACROS_SVH
`define UTF8_STREAM_VALIDATOR_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define UTF8V_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utf8v: same-cycle check failed");

// next-cycle implication
`define UTF8V_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utf8v: next-cycle check failed");

`else

`define UTF8V_ASSERT_NOW(name, ante, cons)
`define UTF8V_ASSERT_NEXT(name, ante, cons)

`endif

`endif

FILE: design/utf8v_pkg.sv
// Shared types and byte-class constants for the UTF-8 stream validator.
// No dependencies.
package utf8v_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_beat_t;

  typedef struct packed {
    logic error_seen;
    logic message_end;
    logic message_valid;
  } result_t;

  typedef struct packed {
    logic [1:0]  bytes_pending;
    logic [20:0] code_accum;
    logic [1:0]  lead_length;
    logic        error_flag;
  } dec_state_t;

  localparam logic [7:0] ASCII_NUL = 8'h00;
  localparam logic [7:0] ASCII_MIN = 8'h01;
  localparam logic [7:0] ASCII_MAX = 8'h7f;
  localparam logic [7:0] LEAD2_LO  = 8'hc2;
  localparam logic [7:0] LEAD2_HI  = 8'hdf;
  localparam logic [7:0] LEAD3_LO  = 8'he0;
  localparam logic [7:0] LEAD3_HI  = 8'hef;
  localparam logic [7:0] LEAD4_LO  = 8'hf0;
  localparam logic [7:0] LEAD4_HI  = 8'hf4;
  localparam logic [7:0] CONT_MASK = 8'hc0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  localparam logic [20:0] SURR_LO   = 21'h00d800;
  localparam logic [20:0] SURR_HI   = 21'h00dfff;
  localparam logic [20:0] CP_MAX    = 21'h10ffff;
  localparam logic [20:0] CP_3B_MIN = 21'h000800;
  localparam logic [20:0] CP_4B_MIN = 21'h010000;

  // continuation bytes announced by the lead byte
  localparam logic [1:0] LEN_NONE = 2'd0;
  localparam logic [1:0] LEN_2B   = 2'd1;
  localparam logic [1:0] LEN_3B   = 2'd2;
  localparam logic [1:0] LEN_4B   = 2'd3;

endpackage

FILE: design/utf8v_if.sv
// Valid/ready channel interfaces: byte beats in, per-byte results out.
// No dependencies.
interface utf8v_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface utf8v_result_if;
  logic valid;
  logic ready;
  logic error_seen;
  logic message_end;
  logic message_valid;

  modport source (output valid, output error_seen, output message_end,
                  output message_valid, input ready);
  modport sink   (input valid, input error_seen, input message_end,
                  input message_valid, output ready);
endinterface

FILE: design/utf8v_in_stage.sv
// Input register for byte beats.
// Depends on utf8v_pkg and utf8v_byte_if.
module utf8v_in_stage import utf8v_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  utf8v_byte_if.sink   in_byte,
  input  logic         take,
  output logic         beat_valid,
  output byte_beat_t   beat
);

  logic       valid_r;
  byte_beat_t beat_r;

  // refill in the same cycle the held beat moves on
  assign in_byte.ready = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_byte.ready) begin
      valid_r <= in_byte.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_byte.valid && in_byte.ready) begin
      beat_r.data_byte <= in_byte.data_byte;
      beat_r.last_byte <= in_byte.last_byte;
    end
  end

  assign beat_valid = valid_r;
  assign beat       = beat_r;

endmodule

FILE: design/utf8v_decoder.sv
// Per-byte UTF-8 decode step with the message state registers.
// Depends on utf8v_pkg.
module utf8v_decoder import utf8v_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  byte_beat_t beat,
  output result_t    res,
  output dec_state_t state
);

  dec_state_t  st_r;
  dec_state_t  upd;
  dec_state_t  st_nxt;
  logic        err_hit;
  logic [7:0]  b;
  logic [20:0] cp;

  assign b  = beat.data_byte;
  assign cp = {st_r.code_accum[14:0], b[5:0]};

  always_comb begin
    upd     = st_r;
    err_hit = 1'b0;
    // once flagged, the decode state freezes until the message ends
    if (!st_r.error_flag) begin
      if (st_r.bytes_pending == LEN_NONE) begin
        case (b) inside
          ASCII_NUL: err_hit = 1'b1;
          [ASCII_MIN:ASCII_MAX]: err_hit = 1'b0;
          [LEAD2_LO:LEAD2_HI]: begin
            upd.code_accum    = {16'b0, b[4:0]};
            upd.bytes_pending = LEN_2B;
            upd.lead_length   = LEN_2B;
          end
          [LEAD3_LO:LEAD3_HI]: begin
            upd.code_accum    = {17'b0, b[3:0]};
            upd.bytes_pending = LEN_3B;
            upd.lead_length   = LEN_3B;
          end
          [LEAD4_LO:LEAD4_HI]: begin
            upd.code_accum    = {18'b0, b[2:0]};
            upd.bytes_pending = LEN_4B;
            upd.lead_length   = LEN_4B;
          end
          default: err_hit = 1'b1;
        endcase
      end else if ((b & CONT_MASK) != CONT_TAG) begin
        err_hit = 1'b1;
      end else begin
        upd.code_accum    = cp;
        upd.bytes_pending = st_r.bytes_pending - 2'd1;
        // range checks on the final continuation byte
        if (st_r.bytes_pending == LEN_2B) begin
          if ((cp >= SURR_LO && cp <= SURR_HI) || cp > CP_MAX ||
              (cp < CP_3B_MIN && (st_r.lead_length == LEN_3B ||
                                  st_r.lead_length == LEN_4B)) ||
              (cp < CP_4B_MIN && st_r.lead_length == LEN_4B)) begin
            err_hit = 1'b1;
          end
        end
      end
    end
    upd.error_flag = st_r.error_flag | err_hit |
                     (beat.last_byte && upd.bytes_pending != LEN_NONE);

    res.error_seen    = upd.error_flag;
    res.message_end   = beat.last_byte;
    res.message_valid = beat.last_byte && !upd.error_flag;

    st_nxt = beat.last_byte ? '0 : upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  assign state = st_r;

endmodule

FILE: design/utf8v_out_stage.sv
// Result register driving the output channel.
// Depends on utf8v_pkg and utf8v_result_if.
module utf8v_out_stage import utf8v_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  result_t         res_in,
  utf8v_result_if.source  out_res,
  output logic            free
);

  logic    valid_r;
  result_t res_r;

  assign free = !valid_r || out_res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_res.valid         = valid_r;
  assign out_res.error_seen    = res_r.error_seen;
  assign out_res.message_end   = res_r.message_end;
  assign out_res.message_valid = res_r.message_valid;

endmodule

FILE: design/utf8_stream_validator.sv
// Channel   Dir  Beat payload
// in_byte   in   data_byte[7:0], last_byte
// out_res   out  error_seen, message_end, message_valid
//
// One byte per cycle sustained while the output accepts results; a taken byte passes
// through the input register, then is decoded into the result register.
// The decode state update is the loop that sets the rate.
// Reset (rst_n low, synchronous) empties both registers and clears the message state.
// A stalled output holds its result; the input register still takes a beat while
// the output can drain in the same cycle.
// Top level of the UTF-8 stream validator.
// Depends on utf8v_pkg, utf8v_if, utf8v_in_stage, utf8v_decoder, utf8v_out_stage.
`include "utf8_stream_validator_macros.svh"

module utf8_stream_validator import utf8v_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  utf8v_byte_if.sink      in_byte,
  utf8v_result_if.source  out_res
);

  logic       s1_valid;
  byte_beat_t s1_beat;
  logic       s2_free;
  logic       s1_move;
  result_t    dec_res;
  dec_state_t dec_state;

  assign s1_move = s1_valid && s2_free;

  utf8v_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_byte),
    .take       (s1_move),
    .beat_valid (s1_valid),
    .beat       (s1_beat)
  );

  utf8v_decoder u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (s1_move),
    .beat    (s1_beat),
    .res     (dec_res),
    .state   (dec_state)
  );

  utf8v_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (s1_move),
    .res_in  (dec_res),
    .out_res (out_res),
    .free    (s2_free)
  );

  `UTF8V_ASSERT_NOW(a_verdict_consistent, out_res.valid && out_res.message_valid,
                    out_res.message_end && !out_res.error_seen)
  `UTF8V_ASSERT_NEXT(a_state_clears_at_end, s1_move && s1_beat.last_byte, dec_state == '0)
  `UTF8V_ASSERT_NOW(a_stall_only_from_output, !in_byte.ready,
                    s1_valid && out_res.valid && !out_res.ready)

endmodule

FILE: tb/sv/utf8_stream_validator_test.sv
`timescale 1ns / 100ps
// Self-checking bench for utf8_stream_validator: drives byte beats and scores each result beat.
// Depends on utf8v_pkg, utf8v_if and the validator RTL.

module utf8_stream_validator_test;
  import utf8v_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_BEATS = 200;
  localparam int unsigned MAX_REPORTS = 10;

  // Shadow decoder plus the queue of result beats it still owes.
  class utf8_verdict_board;
    result_t     expected_q[$];
    logic [1:0]  pending_cont;
    logic [20:0] accum;
    logic [1:0]  lead_len;
    logic        err;
    int unsigned mismatches;

    function new();
      clear_message();
      mismatches = 0;
    endfunction

    function void clear_message();
      pending_cont = LEN_NONE;
      accum        = '0;
      lead_len     = LEN_NONE;
      err          = 1'b0;
    endfunction

    function void decode_byte(logic [7:0] b);
      if (pending_cont == LEN_NONE) begin
        if (b <= ASCII_MAX) begin
          if (b == ASCII_NUL) err = 1'b1;
        end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
          accum        = {16'd0, b[4:0]};
          pending_cont = LEN_2B;
          lead_len     = LEN_2B;
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
          accum        = {17'd0, b[3:0]};
          pending_cont = LEN_3B;
          lead_len     = LEN_3B;
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
          accum        = {18'd0, b[2:0]};
          pending_cont = LEN_4B;
          lead_len     = LEN_4B;
        end else begin
          err = 1'b1;
        end
        return;
      end
      if ((b & CONT_MASK) != CONT_TAG) begin
        err = 1'b1;
        return;
      end
      accum        = {accum[14:0], b[5:0]};
      pending_cont = pending_cont - 2'd1;
      // range checks only once the whole code point is in
      if (pending_cont == LEN_NONE) begin
        if ((accum >= SURR_LO && accum <= SURR_HI) || accum > CP_MAX ||
            (accum < CP_3B_MIN && lead_len >= LEN_3B) ||
            (accum < CP_4B_MIN && lead_len == LEN_4B))
          err = 1'b1;
      end
    endfunction

    function void note_byte(byte_beat_t beat);
      result_t r;
      if (!err) decode_byte(beat.data_byte);
      if (beat.last_byte && pending_cont != LEN_NONE) err = 1'b1;
      r.error_seen    = err;
      r.message_end   = beat.last_byte;
      r.message_valid = beat.last_byte && !err;
      expected_q.push_back(r);
      if (beat.last_byte) clear_message();
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result beat: error_seen %0b message_end %0b message_valid %0b",
                   got.error_seen, got.message_end, got.message_valid);
        return;
      end
      want = expected_q.pop_front();
      if (got.error_seen !== want.error_seen || got.message_end !== want.message_end ||
          got.message_valid !== want.message_valid) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"result mismatch: error_seen exp %0b got %0b, ",
                    "message_end exp %0b got %0b, message_valid exp %0b got %0b"},
                   want.error_seen, got.error_seen, want.message_end, got.message_end,
                   want.message_valid, got.message_valid);
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  utf8v_byte_if   in_if ();
  utf8v_result_if out_if ();

  utf8_stream_validator uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_byte (in_if),
    .out_res (out_if)
  );

  utf8_verdict_board board = new();

  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;
  int unsigned beats_sent    = 0;
  int unsigned cycle_count   = 0;
  logic [7:0]  msg_bytes[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // note the input beat before scoring the output beat of the same edge
  always @(posedge clk) begin
    byte_beat_t beat;
    result_t    res;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        beat.data_byte = in_if.data_byte;
        beat.last_byte = in_if.last_byte;
        board.note_byte(beat);
      end
      if (out_if.valid && out_if.ready) begin
        res.error_seen    = out_if.error_seen;
        res.message_end   = out_if.message_end;
        res.message_valid = out_if.message_valid;
        board.check_result(res);
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_msg_bytes();
    for (int i = 0; i < msg_bytes.size(); i++)
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  function automatic void push_code(logic [20:0] cp, int unsigned len);
    case (len)
      1: msg_bytes.push_back(cp[7:0]);
      2: begin
        msg_bytes.push_back({3'b110, cp[10:6]});
        msg_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        msg_bytes.push_back({4'b1110, cp[15:12]});
        msg_bytes.push_back({2'b10, cp[11:6]});
        msg_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        msg_bytes.push_back({5'b11110, cp[20:18]});
        msg_bytes.push_back({2'b10, cp[17:12]});
        msg_bytes.push_back({2'b10, cp[11:6]});
        msg_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic logic [20:0] pick_code(int unsigned len);
    logic [20:0] cp;
    case (len)
      1: cp = 21'($urandom_range(21'h7f, 21'h01));
      2: cp = 21'($urandom_range(21'h7ff, 21'h80));
      3: begin
        cp = 21'($urandom_range(21'hffff, CP_3B_MIN));
        while (cp >= SURR_LO && cp <= SURR_HI)
          cp = 21'($urandom_range(21'hffff, CP_3B_MIN));
      end
      default: cp = 21'($urandom_range(CP_MAX, CP_4B_MIN));
    endcase
    return cp;
  endfunction

  function automatic void add_flaw();
    int unsigned len;
    int unsigned cut;
    logic [7:0]  junk;
    len = $urandom_range(4, 2);
    case ($urandom_range(6))
      0: msg_bytes.push_back(ASCII_NUL);
      1: push_code(21'($urandom_range(SURR_HI, SURR_LO)), 3);
      2: begin
        // overlong three- or four-byte form
        if ($urandom_range(1)) push_code(21'($urandom_range(21'h7ff, 21'h0)), 3);
        else push_code(21'($urandom_range(21'hffff, 21'h0)), 4);
      end
      3: push_code(21'($urandom_range(21'h1fffff, CP_MAX + 21'd1)), 4);
      4: begin
        // sequence cut short
        push_code(pick_code(len), len);
        cut = $urandom_range(len - 1, 1);
        repeat (cut) void'(msg_bytes.pop_back());
      end
      5: begin
        // sequence cut short, then a non-continuation byte
        push_code(pick_code(len), len);
        cut = $urandom_range(len - 1, 1);
        repeat (cut) void'(msg_bytes.pop_back());
        junk = 8'($urandom_range(255));
        if (junk[7:6] == 2'b10) junk[6] = 1'b1;
        msg_bytes.push_back(junk);
      end
      default: msg_bytes.push_back(8'($urandom_range(255)));
    endcase
  endfunction

  task automatic send_random_message();
    int unsigned n;
    int unsigned pick;
    int unsigned len;
    msg_bytes.delete();
    n = $urandom_range(6, 1);
    if ($urandom_range(99) < 10) begin
      repeat (n) msg_bytes.push_back(8'($urandom_range(255)));
    end else begin
      repeat (n) begin
        pick = $urandom_range(99);
        len = (pick < 40) ? 1 : (pick < 60) ? 2 : (pick < 80) ? 3 : 4;
        if (pick >= 92) add_flaw();
        else push_code(pick_code(len), len);
      end
    end
    send_msg_bytes();
  endtask

  initial begin
    int unsigned idle_tab[4];
    int unsigned stall_tab[4];
    int unsigned phase_start;

    idle_tab        = '{0, 80, 0, 25};
    stall_tab       = '{0, 0, 80, 25};
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    msg_bytes = '{ASCII_MAX};                                  send_msg_bytes();
    msg_bytes = '{ASCII_NUL};                                  send_msg_bytes();
    // two-, three- and four-byte extremes in one valid message
    msg_bytes = '{8'hc2, 8'h80, 8'hef, 8'hbf, 8'hbf, 8'hf4, 8'h8f, 8'hbf, 8'hbf};
    send_msg_bytes();
    msg_bytes = '{8'hc1};                                      send_msg_bytes();
    msg_bytes = '{8'he0, 8'h9f, 8'hbf};                        send_msg_bytes();
    msg_bytes = '{8'hed, 8'ha0, 8'h80};                        send_msg_bytes();
    msg_bytes = '{8'hf4, 8'h90, 8'h80, 8'h80};                 send_msg_bytes();
    msg_bytes = '{8'hf0, 8'h8f, 8'hbf, 8'hbf};                 send_msg_bytes();
    msg_bytes = '{8'he0, 8'ha0};                               send_msg_bytes();
    // bad continuation, then a byte that must be ignored
    msg_bytes = '{8'hc2, 8'h41, 8'hff};                        send_msg_bytes();
    drain();

    for (int p = 0; p < 4; p++) begin
      in_idle_pct   = idle_tab[p];
      out_stall_pct = stall_tab[p];
      phase_start   = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) send_random_message();
      drain();
    end

    in_idle_pct   = 0;
    out_stall_pct = 0;
    repeat (10) @(posedge clk);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
